// ----- rtl/bls_pkg.sv -----
package bls_pkg;

  localparam int unsigned BLS_DEPTH = 8;
  localparam int unsigned WORD_W    = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DUMP = 2'd3
  } bls_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } bls_status_e;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_PUSH = 2'd1,
    SHIFT_POP  = 2'd2,
    SHIFT_ROT  = 2'd3
  } bls_shift_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } bls_fsm_e;

  typedef struct packed {
    bls_shift_e mode;
    logic       wrap;
  } bls_cell_ctrl_t;

  typedef struct packed {
    bls_op_e                    opcode;
    logic signed [WORD_W-1:0]   push_value;
  } bls_in_t;

  typedef struct packed {
    bls_status_e                status;
    logic signed [WORD_W-1:0]   data_word;
    logic                       is_empty;
    logic                       is_full;
    logic                       last_result;
  } bls_out_t;

endpackage

// ----- rtl/bls_cell.sv -----
module bls_cell import bls_pkg::*; (
  input  logic                     clk_i,
  input  bls_cell_ctrl_t           ctrl_i,
  input  logic signed [WORD_W-1:0] from_above_i,
  input  logic signed [WORD_W-1:0] from_below_i,
  input  logic signed [WORD_W-1:0] from_top_i,
  output logic signed [WORD_W-1:0] data_o
);

  logic signed [WORD_W-1:0] data_q, data_d;

  always_comb begin
    unique case (ctrl_i.mode)
      SHIFT_HOLD: data_d = data_q;
      SHIFT_PUSH: data_d = from_above_i;
      SHIFT_POP:  data_d = from_below_i;
      // The deepest occupied cell closes the ring by taking the top word.
      SHIFT_ROT:  data_d = ctrl_i.wrap ? from_top_i : from_below_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/bounded_lifo_stack.sv -----
// Channel | Direction | Payload   | Handshake
// in      | input     | bls_in_t  | in_valid_i / in_ready_o
// out     | output    | bls_out_t | out_valid_o / out_ready_i
//
// Push, pop and peek give one beat each; an item is taken every cycle while no
// dump runs and the output register is free or being drained. A dump of N words
// sends one beat per cycle unless stalled and holds input ready low until its
// last beat is registered, as the cell chain rotates once per beat and so ends
// in its original order. Reset empties the stack at once; the stored words are
// not cleared. A stalled beat freezes the chain and blocks input until taken.
module bounded_lifo_stack import bls_pkg::*; #(
  parameter int unsigned DEPTH = BLS_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bls_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bls_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  bls_fsm_e        state_q, state_d;
  logic            out_valid_q, out_valid_d;
  bls_out_t        out_q, out_d;
  bls_shift_e      mode;

  logic signed [WORD_W-1:0] cell_data [DEPTH];

  logic slot_free, in_fire, dump_step, count_zero, count_full;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == FSM_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign dump_step  = (state_q == FSM_DUMP) && slot_free;
  assign count_zero = (count_q == '0);
  assign count_full = (count_q == CntW'(DEPTH));

  always_comb begin
    count_d     = count_q;
    rem_d       = rem_q;
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mode        = SHIFT_HOLD;

    if (in_fire) begin
      out_valid_d       = 1'b1;
      out_d.status      = ST_OK;
      out_d.data_word   = '0;
      out_d.last_result = 1'b1;
      unique case (in_data_i.opcode)
        OP_PUSH: begin
          if (count_full) begin
            out_d.status = ST_OVERFLOW;
          end else begin
            mode    = SHIFT_PUSH;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP: begin
          if (count_zero) begin
            out_d.status = ST_UNDERFLOW;
          end else begin
            out_d.data_word = cell_data[0];
            mode            = SHIFT_POP;
            count_d         = count_q - 1'b1;
          end
        end
        OP_PEEK: begin
          if (count_zero) begin
            out_d.status = ST_UNDERFLOW;
          end else begin
            out_d.data_word = cell_data[0];
          end
        end
        OP_DUMP: begin
          if (count_zero) begin
            out_d.status = ST_UNDERFLOW;
          end else begin
            out_d.data_word = cell_data[0];
            mode            = SHIFT_ROT;
            if (count_q != CntW'(1)) begin
              out_d.last_result = 1'b0;
              rem_d             = count_q - 1'b1;
              state_d           = FSM_DUMP;
            end
          end
        end
        default: out_d.status = ST_UNDERFLOW;
      endcase
      out_d.is_empty = (count_d == '0);
      out_d.is_full  = (count_d == CntW'(DEPTH));
    end else if (dump_step) begin
      out_valid_d       = 1'b1;
      out_d.status      = ST_OK;
      out_d.data_word   = cell_data[0];
      out_d.is_empty    = count_zero;
      out_d.is_full     = count_full;
      out_d.last_result = (rem_q == CntW'(1));
      mode              = SHIFT_ROT;
      rem_d             = rem_q - 1'b1;
      if (rem_q == CntW'(1)) begin
        state_d = FSM_IDLE;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bls_cell_ctrl_t           ctrl;
    logic signed [WORD_W-1:0] above, below;

    assign ctrl.mode = mode;
    assign ctrl.wrap = (count_q == CntW'(i + 1));

    if (i == 0) begin : g_top
      assign above = in_data_i.push_value;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign below = cell_data[i];
    end else begin : g_inner
      assign below = cell_data[i+1];
    end

    bls_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .from_above_i (above),
      .from_below_i (below),
      .from_top_i   (cell_data[0]),
      .data_o       (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rem_q       <= '0;
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rem_q       <= rem_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_dump_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_DUMP |-> rem_q != '0 && rem_q < count_q)
    else $error("dump beats left out of range");

  a_dump_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_DUMP |=> count_q == $past(count_q))
    else $error("stack size changed during dump");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OVERFLOW |-> out_data_o.is_full)
    else $error("overflow reported on a stack that is not full");

endmodule

// ----- verif/bounded_lifo_stack_tb.sv -----
`timescale 1ns / 1ps

module bounded_lifo_stack_tb;
  import bls_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bls_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bls_out_t out_data;

  bls_in_t  pending_items[$];
  bls_out_t expected_beats[$];

  // Shadow copy of the stack contents.
  logic [WORD_W-1:0] stack_words [BLS_DEPTH];
  int                stack_count = 0;

  int error_count = 0;
  int gap_left    = 0;
  int burst_left  = 1;

  bounded_lifo_stack uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  function automatic void expect_beat(bls_status_e st, logic [WORD_W-1:0] word, logic last);
    bls_out_t beat;
    beat.status      = st;
    beat.data_word   = word;
    beat.is_empty    = (stack_count == 0);
    beat.is_full     = (stack_count >= BLS_DEPTH);
    beat.last_result = last;
    expected_beats.push_back(beat);
  endfunction

  function automatic void stack_step(bls_in_t item);
    case (item.opcode)
      OP_PUSH: begin
        if (stack_count >= BLS_DEPTH) begin
          expect_beat(ST_OVERFLOW, '0, 1'b1);
        end else begin
          stack_words[stack_count] = item.push_value;
          stack_count++;
          expect_beat(ST_OK, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (stack_count == 0) begin
          expect_beat(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          stack_count--;
          expect_beat(ST_OK, stack_words[stack_count], 1'b1);
        end
      end
      OP_PEEK: begin
        if (stack_count == 0) begin
          expect_beat(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          expect_beat(ST_OK, stack_words[stack_count-1], 1'b1);
        end
      end
      default: begin
        if (stack_count == 0) begin
          expect_beat(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          for (int i = stack_count; i > 0; i--) begin
            expect_beat(ST_OK, stack_words[i-1], i == 1);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_item(bls_op_e op, logic [WORD_W-1:0] word);
    bls_in_t item;
    item.opcode     = op;
    item.push_value = word;
    pending_items.push_back(item);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random from four modes, and twice it holds
  // off long enough for the block to back up and stall its input.
  int ready_cycle = 0;
  int hold_left   = 0;
  int ready_mode  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle == 150 || ready_cycle == 700) begin
        hold_left <= 100;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (ready_cycle % 64 == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: predicts on every input beat, checks every output beat.
  always @(posedge clk) begin : monitor
    bls_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) stack_step(in_data);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          error_count++;
          $display("%0t: output beat with nothing expected, actual %0h", $time, out_data);
        end else begin
          want = expected_beats.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(out_data.status));
          check_field("data_word", want.data_word, out_data.data_word);
          check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_data.is_empty));
          check_field("is_full", WORD_W'(want.is_full), WORD_W'(out_data.is_full));
          check_field("last_result", WORD_W'(want.last_result),
                      WORD_W'(out_data.last_result));
        end
      end
    end
  end

  initial begin
    int push_pct;
    int run_left;
    int pick;
    bls_op_e op;

    // Empty stack: every reading operation underflows.
    add_item(OP_DUMP, 32'h1234_5678);
    add_item(OP_POP, 32'hffff_ffff);
    add_item(OP_PEEK, 32'h0);
    // Fill to the top and one push beyond, with extreme and alternating patterns.
    add_item(OP_PUSH, 32'h7fff_ffff);
    add_item(OP_PUSH, 32'h8000_0000);
    add_item(OP_PUSH, 32'h0000_0000);
    add_item(OP_PUSH, 32'hffff_ffff);
    add_item(OP_PUSH, 32'h0000_0001);
    add_item(OP_PUSH, 32'haaaa_aaaa);
    add_item(OP_PUSH, 32'h5555_5555);
    add_item(OP_PUSH, 32'h1234_5678);
    add_item(OP_PUSH, 32'hdead_beef);
    add_item(OP_PEEK, 32'h0);
    add_item(OP_DUMP, 32'h0);
    add_item(OP_POP, 32'h0);
    add_item(OP_POP, 32'h0);
    add_item(OP_PEEK, 32'h0);
    add_item(OP_DUMP, 32'h0);

    // Random runs alternate between filling, draining and churning.
    push_pct = 50;
    run_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 30);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      run_left--;
      pick = $urandom_range(0, 99);
      if (pick < 8) op = OP_DUMP;
      else if (pick < 18) op = OP_PEEK;
      else if (pick < 18 + push_pct * 82 / 100) op = OP_PUSH;
      else op = OP_POP;
      add_item(op, pick_word());
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bls_pkg.sv
rtl/bls_cell.sv
rtl/bounded_lifo_stack.sv
verif/bounded_lifo_stack_tb.sv
